/* design/mrwt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared width constants and payload types of the Miller-Rabin witness test.
// ----------------------------------------------------------------------------
package mrwt_pkg;

  localparam int unsigned NumBits  = 32;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ProdW    = 2 * NumBits;
  localparam int unsigned CntW     = $clog2(ProdW + 1);

  typedef logic [NumBits-1:0] num_t;
  typedef logic [ProdW-1:0]   prod_t;

  typedef struct packed {
    logic [WordW-1:0] candidate;
    logic [WordW-1:0] witness;
  } in_word_t;

  typedef struct packed {
    logic probably_prime;
  } out_word_t;

endpackage
`default_nettype wire

/* design/mrwt_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrwt_in_if / mrwt_out_if
// Valid-ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface mrwt_in_if;
  logic               valid;
  logic               ready;
  mrwt_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrwt_out_if;
  logic                valid;
  logic                ready;
  mrwt_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/miller_rabin_witness_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// One Miller-Rabin round per word: candidate n, witness w, probably_prime.
// ----------------------------------------------------------------------------
// One word at a time; ready is low from acceptance until the result word is
// taken. All time goes to the shared modular multiplier: one reduction of w,
// one multiply per set bit of q, one squaring per further bit of q and one
// per extra squaring. Candidates zero and one are answered in StSplit
// without a multiply.
module miller_rabin_witness_test (
  input  wire        clk_i,
  input  wire        rst_ni,
  mrwt_in_if.sink    in_i,
  mrwt_out_if.source out_o
);

  typedef enum logic [2:0] {
    StIdle, StSplit, StRedW, StSq, StMulAcc, StCheck, StLoop, StOut
  } state_e;

  state_e                    state_q;
  mrwt_pkg::num_t            n_q, nm1_q, q_q, base_q, acc_q, w_q;
  logic [mrwt_pkg::CntW-1:0] k_q;
  logic                      busy_q;
  logic                      res_q;
  logic                      start_q;
  mrwt_pkg::num_t            ma_q, mb_q;

  logic                      mm_done;
  mrwt_pkg::num_t            mm_r;

  mrwt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .a_i    (ma_q),
    .b_i    (mb_q),
    .m_i    (n_q),
    .done_o (mm_done),
    .r_o    (mm_r)
  );

  assign in_i.ready               = (state_q == StIdle);
  assign out_o.valid              = (state_q == StOut);
  assign out_o.data.probably_prime = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      start_q <= 1'b0;
      busy_q  <= 1'b0;
      res_q   <= 1'b0;
      k_q     <= '0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            n_q   <= in_i.data.candidate[mrwt_pkg::NumBits-1:0];
            w_q   <= in_i.data.witness[mrwt_pkg::NumBits-1:0];
            nm1_q <= in_i.data.candidate[mrwt_pkg::NumBits-1:0] - 1'b1;
            q_q   <= in_i.data.candidate[mrwt_pkg::NumBits-1:0] - 1'b1;
            k_q   <= '0;
            state_q <= StSplit;
          end
        end
        StSplit: begin
          if (n_q == '0) begin
            res_q <= 1'b0; state_q <= StOut;
          end else if (n_q == mrwt_pkg::num_t'(1)) begin
            res_q <= 1'b1; state_q <= StOut;
          end else if (!q_q[0]) begin
            q_q <= q_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            acc_q   <= mrwt_pkg::num_t'(1);
            ma_q    <= w_q;
            mb_q    <= mrwt_pkg::num_t'(1);
            start_q <= 1'b1;
            busy_q  <= 1'b1;
            state_q <= StRedW;
          end
        end
        StRedW: begin
          if (mm_done) begin
            base_q  <= mm_r;
            state_q <= StMulAcc;
            busy_q  <= 1'b0;
          end
        end
        StMulAcc: begin
          if (!busy_q) begin
            if (q_q[0]) begin
              ma_q <= acc_q; mb_q <= base_q; start_q <= 1'b1; busy_q <= 1'b1;
            end else begin
              state_q <= StSq;
            end
          end else if (mm_done) begin
            acc_q <= mm_r; busy_q <= 1'b0; state_q <= StSq;
          end
        end
        StSq: begin
          if (!busy_q) begin
            if (q_q >> 1 == '0) begin
              state_q <= StCheck;
            end else begin
              ma_q <= base_q; mb_q <= base_q; start_q <= 1'b1; busy_q <= 1'b1;
            end
          end else if (mm_done) begin
            base_q <= mm_r; busy_q <= 1'b0; q_q <= q_q >> 1;
            state_q <= StMulAcc;
          end
        end
        StCheck: begin
          if (acc_q == mrwt_pkg::num_t'(1) || acc_q == nm1_q) begin
            res_q <= 1'b1; state_q <= StOut;
          end else if (k_q <= mrwt_pkg::CntW'(1)) begin
            res_q <= 1'b0; state_q <= StOut;
          end else begin
            k_q <= k_q - 1'b1;
            ma_q <= acc_q; mb_q <= acc_q; start_q <= 1'b1; busy_q <= 1'b1;
            state_q <= StLoop;
          end
        end
        StLoop: begin
          if (mm_done) begin
            acc_q  <= mm_r;
            busy_q <= 1'b0;
            if (mm_r == nm1_q) begin
              res_q <= 1'b1; state_q <= StOut;
            end else if (mm_r == mrwt_pkg::num_t'(1)) begin
              res_q <= 1'b0; state_q <= StOut;
            end else if (k_q <= mrwt_pkg::CntW'(1)) begin
              res_q <= 1'b0; state_q <= StOut;
            end else begin
              k_q <= k_q - 1'b1;
              ma_q <= mm_r; mb_q <= mm_r; start_q <= 1'b1; busy_q <= 1'b1;
            end
          end
        end
        StOut: begin
          if (out_o.ready) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> busy_q) else $error("start without busy");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(res_q)))
    else $error("result dropped");
  a_q_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRedW) |-> q_q[0]) else $error("q not odd");
`endif

endmodule
`default_nettype wire

/* design/mrwt_modmul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrwt_modmul
// Shared modular multiplier: one 32x32 product, then a restoring reduction
// of one bit per cycle, giving a * b mod m on r_o when done_o is raised.
// ----------------------------------------------------------------------------
module mrwt_modmul (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  mrwt_pkg::num_t  a_i,
  input  mrwt_pkg::num_t  b_i,
  input  mrwt_pkg::num_t  m_i,
  output logic            done_o,
  output mrwt_pkg::num_t  r_o
);

  typedef enum logic [1:0] {StIdle, StMul, StRed} state_e;

  state_e                     state_q;
  mrwt_pkg::prod_t            prod_q;
  logic [mrwt_pkg::NumBits:0] rem_q;
  mrwt_pkg::num_t             a_q, b_q, m_q;
  logic [mrwt_pkg::CntW-1:0]  cnt_q;

  logic [mrwt_pkg::NumBits:0] shift_d;
  logic [mrwt_pkg::NumBits:0] sub_d;

  always_comb begin
    shift_d = {rem_q[mrwt_pkg::NumBits-1:0], prod_q[mrwt_pkg::ProdW-1]};
    sub_d   = shift_d - {1'b0, m_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            m_q     <= m_i;
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= mrwt_pkg::prod_t'(a_q) * mrwt_pkg::prod_t'(b_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StRed;
        end
        StRed: begin
          prod_q <= {prod_q[mrwt_pkg::ProdW-2:0], 1'b0};
          if (sub_d[mrwt_pkg::NumBits]) rem_q <= shift_d;
          else                          rem_q <= sub_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == mrwt_pkg::CntW'(mrwt_pkg::ProdW - 1)) begin
            done_o  <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign r_o = rem_q[mrwt_pkg::NumBits-1:0];

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, m_q} > rem_q)) else $error("remainder not reduced");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |=> (state_q == StRed)) else $error("bad sequence");
`endif

endmodule
`default_nettype wire
